>>> hw/rtl/psrw_pkg.sv
package psrw_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int TOTAL_W = $clog2(TABLE_ENTRIES + 1);

   localparam int MAC_W = 48;
   localparam int TICK_W = 32;
   localparam int COUNT_W = 16;
   localparam int STATUS_W = 2;
   localparam int FLAGGED_TOTAL_W = 5;
   localparam int TOTAL_EXT_W = (TOTAL_W > FLAGGED_TOTAL_W) ? TOTAL_W : FLAGGED_TOTAL_W;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TOTAL_EXT_W-1:0] TOTAL_MAX = TOTAL_EXT_W'(31);

   localparam logic [TICK_W-1:0] WINDOW_LENGTH_RESET = TICK_W'(1000);
   localparam logic [COUNT_W-1:0] FLAG_THRESHOLD_RESET = COUNT_W'(100);

   localparam logic ACTION_OBSERVE = 1'b0;
   localparam logic ACTION_CHECK = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LENGTH = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FLAG_THRESHOLD = CSR_INDEX_W'(1);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_MATCHED = 2'd0,
      STATUS_CREATED = 2'd1,
      STATUS_FULL = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic load_req;
      logic latch_match;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

>>> hw/rtl/per_source_rate_watchlist_top.sv
// Per-source frame rate watchlist. A table of 16 source MAC addresses is held in
// flip-flops, each entry with a window start time, a saturating frame count and a flag.
// An observe transaction (action 0) counts a frame for its MAC, creating an entry in
// the lowest free slot on a miss, and a check transaction (action 1) only looks up.
// A request passes through registered steps before its result reaches the output
// register: the request is captured when it is accepted, the parallel compare of the
// address against all entries is registered, and then, once the output register is
// free, the selected entry is read, updated and written back together with the result.
// A new request is taken in the cycle after the previous result has moved into the
// output register, so no new request is taken while one is in flight. The number
// of flagged entries is kept as a running total rather than counted across the table.
// Configuration writes are accepted every cycle and must be issued while idle.
module per_source_rate_watchlist_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_action,
   input  logic [psrw_pkg::MAC_W-1:0] req_mac_address,
   input  logic [psrw_pkg::TICK_W-1:0] req_now_ticks,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_flagged,
   output logic [psrw_pkg::STATUS_W-1:0] rsp_status,
   output logic [psrw_pkg::FLAGGED_TOTAL_W-1:0] rsp_flagged_total,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [psrw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psrw_pkg::CSR_DATA_W-1:0] csr_data
);

   psrw_pkg::ctrl_cmd_type ctrl_cmd;
   psrw_pkg::dp_status_type dp_status;

   assign csr_ready = 1'b1;

   psrw_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .dp_status(dp_status),
      .ctrl_cmd(ctrl_cmd)
   );

   psrw_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .ctrl_cmd(ctrl_cmd),
      .dp_status(dp_status),
      .req_action(req_action),
      .req_mac_address(req_mac_address),
      .req_now_ticks(req_now_ticks),
      .csr_write(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_flagged(rsp_flagged),
      .rsp_status(rsp_status),
      .rsp_flagged_total(rsp_flagged_total)
   );

endmodule

>>> hw/rtl/psrw_ctrl.sv
module psrw_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  psrw_pkg::dp_status_type dp_status,
   output psrw_pkg::ctrl_cmd_type ctrl_cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MATCH = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      ctrl_cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl_cmd.load_req = 1'b1;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            ctrl_cmd.latch_match = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (dp_status.out_free) begin
               ctrl_cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/psrw_datapath.sv
module psrw_datapath (
   input  logic clock,
   input  logic reset,
   input  psrw_pkg::ctrl_cmd_type ctrl_cmd,
   output psrw_pkg::dp_status_type dp_status,
   input  logic req_action,
   input  logic [psrw_pkg::MAC_W-1:0] req_mac_address,
   input  logic [psrw_pkg::TICK_W-1:0] req_now_ticks,
   input  logic csr_write,
   input  logic [psrw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psrw_pkg::CSR_DATA_W-1:0] csr_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_flagged,
   output logic [psrw_pkg::STATUS_W-1:0] rsp_status,
   output logic [psrw_pkg::FLAGGED_TOTAL_W-1:0] rsp_flagged_total
);

   localparam int N = psrw_pkg::TABLE_ENTRIES;

   logic [psrw_pkg::TICK_W-1:0] window_length_ff;
   logic [psrw_pkg::COUNT_W-1:0] flag_threshold_ff;

   logic [psrw_pkg::MAC_W-1:0] entry_mac_ff [N];
   logic [psrw_pkg::TICK_W-1:0] entry_start_ff [N];
   logic [psrw_pkg::COUNT_W-1:0] entry_count_ff [N];
   logic [N-1:0] entry_flagged_ff;
   logic [N-1:0] entry_valid_ff;
   logic [psrw_pkg::TOTAL_W-1:0] total_ff;

   logic action_ff;
   logic [psrw_pkg::MAC_W-1:0] mac_ff;
   logic [psrw_pkg::TICK_W-1:0] now_ff;

   logic hit_ff;
   logic free_ff;
   logic [psrw_pkg::IDX_W-1:0] sel_idx_ff;

   logic hit_c;
   logic free_c;
   logic [psrw_pkg::IDX_W-1:0] hit_idx_c;
   logic [psrw_pkg::IDX_W-1:0] free_idx_c;

   logic rsp_valid_ff;
   logic rsp_flagged_ff;
   psrw_pkg::status_type rsp_status_ff;
   logic [psrw_pkg::FLAGGED_TOTAL_W-1:0] rsp_total_ff;

   logic [psrw_pkg::TICK_W-1:0] old_start;
   logic [psrw_pkg::COUNT_W-1:0] old_count;
   logic old_flag;
   logic [psrw_pkg::TICK_W-1:0] elapsed;
   logic restart;
   logic do_write;
   logic [psrw_pkg::COUNT_W-1:0] count_base;
   logic [psrw_pkg::COUNT_W-1:0] count_in;
   logic [psrw_pkg::TICK_W-1:0] start_in;
   logic flag_in;
   logic result_flag;
   psrw_pkg::status_type result_status;
   logic [psrw_pkg::TOTAL_W-1:0] total_in;
   logic [psrw_pkg::TOTAL_EXT_W-1:0] total_ext;

   assign dp_status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= psrw_pkg::WINDOW_LENGTH_RESET;
         flag_threshold_ff <= psrw_pkg::FLAG_THRESHOLD_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            psrw_pkg::REG_WINDOW_LENGTH: begin
               window_length_ff <= csr_data[psrw_pkg::TICK_W-1:0];
            end
            psrw_pkg::REG_FLAG_THRESHOLD: begin
               flag_threshold_ff <= csr_data[psrw_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.load_req) begin
         action_ff <= req_action;
         mac_ff <= req_mac_address;
         now_ff <= req_now_ticks;
      end
   end

   // The lowest matching or free slot wins; at most one slot can match.
   always_comb begin
      hit_c = 1'b0;
      free_c = 1'b0;
      hit_idx_c = '0;
      free_idx_c = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (entry_valid_ff[i] && (entry_mac_ff[i] == mac_ff)) begin
            hit_c = 1'b1;
            hit_idx_c = psrw_pkg::IDX_W'(i);
         end
         if (!entry_valid_ff[i]) begin
            free_c = 1'b1;
            free_idx_c = psrw_pkg::IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.latch_match) begin
         hit_ff <= hit_c;
         free_ff <= free_c;
         sel_idx_ff <= hit_c ? hit_idx_c : free_idx_c;
      end
   end

   always_comb begin
      old_start = entry_start_ff[sel_idx_ff];
      old_count = entry_count_ff[sel_idx_ff];
      old_flag = entry_flagged_ff[sel_idx_ff];
      elapsed = now_ff - old_start;
      restart = !hit_ff || (elapsed > window_length_ff);
      do_write = (action_ff == psrw_pkg::ACTION_OBSERVE) && (hit_ff || free_ff);
      count_base = restart ? '0 : old_count;
      count_in = (count_base == psrw_pkg::COUNT_MAX) ? count_base
                                                     : count_base + psrw_pkg::COUNT_W'(1);
      start_in = restart ? now_ff : old_start;
      flag_in = (count_in >= flag_threshold_ff) || (!restart && old_flag);

      if (action_ff == psrw_pkg::ACTION_CHECK) begin
         result_flag = hit_ff && old_flag;
         result_status = hit_ff ? psrw_pkg::STATUS_MATCHED : psrw_pkg::STATUS_NOT_FOUND;
      end else begin
         result_flag = do_write && flag_in;
         if (hit_ff) begin
            result_status = psrw_pkg::STATUS_MATCHED;
         end else if (free_ff) begin
            result_status = psrw_pkg::STATUS_CREATED;
         end else begin
            result_status = psrw_pkg::STATUS_FULL;
         end
      end

      total_in = total_ff;
      if (do_write) begin
         total_in = total_ff - psrw_pkg::TOTAL_W'(hit_ff && old_flag)
                    + psrw_pkg::TOTAL_W'(flag_in);
      end
      total_ext = psrw_pkg::TOTAL_EXT_W'(total_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         entry_flagged_ff <= '0;
         total_ff <= '0;
      end else if (ctrl_cmd.commit && do_write) begin
         entry_valid_ff[sel_idx_ff] <= 1'b1;
         entry_flagged_ff[sel_idx_ff] <= flag_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.commit && do_write) begin
         entry_mac_ff[sel_idx_ff] <= mac_ff;
         entry_start_ff[sel_idx_ff] <= start_in;
         entry_count_ff[sel_idx_ff] <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl_cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.commit) begin
         rsp_flagged_ff <= result_flag;
         rsp_status_ff <= result_status;
         rsp_total_ff <= (total_ext > psrw_pkg::TOTAL_MAX)
                         ? psrw_pkg::FLAGGED_TOTAL_W'(psrw_pkg::TOTAL_MAX)
                         : psrw_pkg::FLAGGED_TOTAL_W'(total_ext);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_flagged = rsp_flagged_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_flagged_total = rsp_total_ff;

endmodule
